@@ hw/rtl/qas_pkg.sv @@
package qas_pkg;

	// Saturation limits of the parser counters
	localparam int unsigned MAX_BACKSLASH_RUN = 31;
	localparam int unsigned MAX_ELEMENTS      = 255;

	localparam int unsigned RUN_W  = 5;
	localparam int unsigned CNT_W  = 8;
	localparam int unsigned CHAR_W = 8;

	// Result queue sizing
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QLVL_W = $clog2(QDEPTH + 1);

	// Packed output data width: out_char, backslashes_before, element_index, padded to bytes
	localparam int unsigned ODATA_BITS = CHAR_W + RUN_W + CNT_W;
	localparam int unsigned ODATA_W    = ((ODATA_BITS + 7) / 8) * 8;

	// Byte codes
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
	localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;

	typedef enum logic [1:0] {
		KIND_CHAR     = 2'd0,
		KIND_ELEM_END = 2'd1,
		KIND_STR_END  = 2'd2,
		KIND_RUN      = 2'd3
	} qas_kind_t;

	typedef struct packed {
		qas_kind_t          kind;
		logic [CHAR_W-1:0]  out_char;
		logic [RUN_W-1:0]   backslashes_before;
		logic [CNT_W-1:0]   element_index;
		logic               last_of_run;
	} qas_result_t;

	// Results produced by one byte, pushed into the queue together
	typedef struct packed {
		logic [1:0]   n;
		qas_result_t  r0;
		qas_result_t  r1;
	} qas_push_t;

	typedef struct packed {
		logic [QLVL_W-1:0] level;
		logic              room;
	} qas_qstat_t;

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage

@@ hw/rtl/qas_parser.sv @@
module qas_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [qas_pkg::CHAR_W-1:0]  in_char,
	input  qas_pkg::qas_qstat_t         qstat,
	output qas_pkg::qas_push_t          push
);
	import qas_pkg::*;

	logic               valid_s1;
	logic [CHAR_W-1:0]  char_s1;
	logic               fire;

	logic               open_q, inq_q, pend_q;
	logic [RUN_W-1:0]   run_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               open_d, inq_d, pend_d;
	logic [RUN_W-1:0]   run_d;
	logic [CNT_W-1:0]   cnt_d;
	logic               inq_e;
	logic [CNT_W-1:0]   idx_now, idx_e;
	logic [RUN_W-1:0]   half;
	qas_push_t          res;

	// Process the held word only when the queue can take two results
	assign fire     = valid_s1 && qstat.room;
	assign in_ready = !valid_s1 || qstat.room;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
		end
	end

	assign idx_now = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
	assign half    = run_q >> 1;

	// One step of the splitter
	always_comb begin
		open_d = open_q;
		inq_d  = inq_q;
		pend_d = 1'b0;
		run_d  = run_q;
		cnt_d  = cnt_q;
		inq_e  = pend_q ? 1'b0 : inq_q;
		idx_e  = idx_now;
		res    = '0;

		if (pend_q && char_s1 == CH_DQUOTE) begin
			// doubled quote inside quotes
			res.n  = 2'd1;
			res.r0 = '{KIND_CHAR, CH_DQUOTE, '0, idx_now, 1'b0};
		end else if (char_s1 == CH_NUL) begin
			if (open_q) begin
				res.n  = 2'd2;
				res.r0 = '{KIND_ELEM_END, CH_NUL, run_q, idx_now, 1'b0};
				res.r1 = '{KIND_STR_END, CH_NUL, '0, cnt_q, 1'b0};
			end else begin
				res.n  = 2'd1;
				res.r0 = '{KIND_STR_END, CH_NUL, '0, cnt_q, 1'b0};
			end
			open_d = 1'b0;
			inq_d  = 1'b0;
			run_d  = '0;
			cnt_d  = '0;
		end else if (!open_q && is_blank(char_s1)) begin
			// skip separators between elements
			inq_d = inq_e;
		end else begin
			inq_d  = inq_e;
			open_d = 1'b1;
			if (!open_q) begin
				if (cnt_q < CNT_W'(MAX_ELEMENTS)) begin
					cnt_d = cnt_q + 1'b1;
				end
				idx_e = (cnt_d != '0) ? cnt_d - 1'b1 : '0;
			end
			if (char_s1 == CH_BSLASH) begin
				if (run_q < RUN_W'(MAX_BACKSLASH_RUN)) begin
					run_d = run_q + 1'b1;
				end
			end else if (char_s1 == CH_DQUOTE) begin
				if (!run_q[0]) begin
					if (inq_e) begin
						pend_d = 1'b1;
					end else begin
						inq_d = 1'b1;
					end
					if (half != '0) begin
						res.n  = 2'd1;
						res.r0 = '{KIND_RUN, CH_NUL, half, idx_e, 1'b0};
					end
				end else begin
					res.n  = 2'd1;
					res.r0 = '{KIND_CHAR, CH_DQUOTE, half, idx_e, 1'b0};
				end
				run_d = '0;
			end else if (!inq_e && is_blank(char_s1)) begin
				res.n  = 2'd1;
				res.r0 = '{KIND_ELEM_END, CH_NUL, run_q, idx_e, 1'b0};
				open_d = 1'b0;
				run_d  = '0;
			end else begin
				res.n  = 2'd1;
				res.r0 = '{KIND_CHAR, char_s1, run_q, idx_e, 1'b0};
				run_d  = '0;
			end
		end

		// Mark the final result of this byte
		res.r0.last_of_run = (res.n == 2'd1);
		res.r1.last_of_run = (res.n == 2'd2);

		push   = res;
		push.n = fire ? res.n : 2'd0;
	end

	// Splitter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			inq_q  <= 1'b0;
			pend_q <= 1'b0;
			run_q  <= '0;
			cnt_q  <= '0;
		end else if (fire) begin
			open_q <= open_d;
			inq_q  <= inq_d;
			pend_q <= pend_d;
			run_q  <= run_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

@@ hw/rtl/qas_outq.sv @@
module qas_outq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qas_pkg::qas_push_t    push,
	output qas_pkg::qas_qstat_t   qstat,
	output logic                  out_valid,
	input  logic                  out_ready,
	output qas_pkg::qas_result_t  out_res
);
	import qas_pkg::*;

	qas_result_t        entry_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QLVL_W-1:0]  level_q;
	logic               pop;
	logic [QPTR_W-1:0]  wr_ptr_p1;

	assign out_valid   = (level_q != '0);
	assign pop         = out_valid && out_ready;
	assign out_res     = entry_q[rd_ptr_q];
	assign wr_ptr_p1   = wr_ptr_q + 1'b1;
	assign qstat.level = level_q;
	assign qstat.room  = (level_q <= QLVL_W'(QDEPTH - 2));

	// Store up to two results per cycle
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			entry_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			entry_q[wr_ptr_p1] <= push.r1;
		end
	end

	// Advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			level_q <= level_q + QLVL_W'(push.n) - QLVL_W'(pop);
		end
	end

endmodule

@@ hw/rtl/quoted_argument_splitter_core.sv @@
// Splits a zero-terminated byte string into whitespace-separated elements with
// Windows command line quoting. One byte enters per word on the slave side; each
// byte yields zero, one or two result words (two only when a zero byte closes an
// open element). A byte is taken every clock while the result queue has room for
// two words, so the sustained rate is one byte per cycle when the master side
// keeps up; a byte reaches its first result through the input register, then the
// result queue. Backslash runs saturate at 31 and the element count at 255.
module quoted_argument_splitter_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,   // [7:0] in_char
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [qas_pkg::ODATA_W-1:0]  m_tdata,   // [7:0] out_char, [12:8] backslashes_before,
	                                                // [20:13] element_index, rest zero
	output logic [1:0]                   m_tuser,   // [1:0] kind
	output logic                         m_tlast    // last_of_run
);
	import qas_pkg::*;

	qas_push_t    push;
	qas_qstat_t   qstat;
	qas_result_t  res;

	qas_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.qstat    (qstat),
		.push     (push)
	);

	qas_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.qstat     (qstat),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Pack result word
	assign m_tdata = ODATA_W'({res.element_index, res.backslashes_before, res.out_char});
	assign m_tuser = res.kind;
	assign m_tlast = res.last_of_run;

	// Queue never overfills
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.level <= QLVL_W'(QDEPTH))
		else $error("result queue level beyond depth");

	// Valid on the master side tracks queue occupancy
	a_valid_level: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid == (qstat.level != '0))
		else $error("m_tvalid disagrees with queue level");

	// A string end word always closes the byte's results
	a_str_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == KIND_STR_END) |-> (m_tlast && m_tdata[12:0] == '0))
		else $error("string end word malformed");

	// A held byte is processed only while two queue slots are free
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |=> (qstat.level <= $past(qstat.level) + QLVL_W'(2)))
		else $error("queue pushed beyond two words");

endmodule

@@ tb/quoted_argument_splitter_core_tb.sv @@
module quoted_argument_splitter_core_tb;
	import qas_pkg::*;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int RANDOM_BYTES   = 750;
	localparam int LONG_HOLD      = 300;
	localparam int HOLD_AT_BYTE   = 300;
	localparam int TAIL_CYCLES    = 20;
	localparam int MAX_REPORTS    = 10;

	// one entry of the sender queue: a byte, or a marker to wait for all results
	typedef struct {
		logic        drain;
		logic [7:0]  ch;
	} tx_entry_t;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [ODATA_W-1:0]  m_tdata;
	logic [1:0]          m_tuser;
	logic                m_tlast;

	quoted_argument_splitter_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	tx_entry_t    byte_q[$];
	qas_result_t  pending_results[$];

	// splitter state as predicted
	logic        p_open       = 1'b0;
	logic        p_quoted     = 1'b0;
	logic        p_quote_wait = 1'b0;
	logic [4:0]  p_bs_run     = '0;
	logic [7:0]  p_count      = '0;

	int  errors        = 0;
	int  bytes_taken   = 0;
	int  results_seen  = 0;
	int  strings_ended = 0;
	int  max_index     = 0;
	int  random_bytes  = 0;
	int  drains_done   = 0;
	int  cycle_count   = 0;
	bit  word_in_taken = 1'b0;
	bit  mid_drain_queued = 1'b0;

	function automatic logic blank_byte(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic qas_result_t mk_result(input qas_kind_t k, input logic [7:0] ch,
			input logic [4:0] bs, input logic [7:0] idx);
		qas_result_t r;
		r.kind               = k;
		r.out_char           = ch;
		r.backslashes_before = bs;
		r.element_index      = idx;
		r.last_of_run        = 1'b0;
		return r;
	endfunction

	function automatic logic [7:0] cur_index();
		return (p_count != 0) ? p_count - 8'd1 : 8'd0;
	endfunction

	// advance the predicted state by one byte and queue the words it yields
	task automatic split_byte(input logic [7:0] c);
		qas_result_t r[$];
		logic        done;
		logic [4:0]  half;
		done = 1'b0;
		// resolve a quote seen inside quotes on the previous byte
		if (p_quote_wait) begin
			p_quote_wait = 1'b0;
			if (c == CH_DQUOTE) begin
				r.push_back(mk_result(KIND_CHAR, CH_DQUOTE, 5'd0, cur_index()));
				done = 1'b1;
			end else begin
				p_quoted = 1'b0;
			end
		end
		// end of string: close the element, report the count, clear everything
		if (!done && c == CH_NUL) begin
			if (p_open)
				r.push_back(mk_result(KIND_ELEM_END, 8'd0, p_bs_run, cur_index()));
			r.push_back(mk_result(KIND_STR_END, 8'd0, 5'd0, p_count));
			p_open   = 1'b0;
			p_quoted = 1'b0;
			p_bs_run = '0;
			p_count  = '0;
			done     = 1'b1;
		end
		// open an element on the first non-blank byte
		if (!done && !p_open) begin
			if (blank_byte(c)) begin
				done = 1'b1;
			end else begin
				p_open = 1'b1;
				if (p_count < MAX_ELEMENTS)
					p_count++;
			end
		end
		if (!done && c == CH_BSLASH) begin
			if (p_bs_run < MAX_BACKSLASH_RUN)
				p_bs_run++;
			done = 1'b1;
		end
		// quote: even run toggles quoting, odd run gives a literal quote
		if (!done && c == CH_DQUOTE) begin
			half = p_bs_run >> 1;
			if (!p_bs_run[0]) begin
				if (p_quoted)
					p_quote_wait = 1'b1;
				else
					p_quoted = 1'b1;
				if (half != 0)
					r.push_back(mk_result(KIND_RUN, 8'd0, half, cur_index()));
			end else begin
				r.push_back(mk_result(KIND_CHAR, CH_DQUOTE, half, cur_index()));
			end
			p_bs_run = '0;
			done     = 1'b1;
		end
		if (!done) begin
			if (!p_quoted && blank_byte(c)) begin
				r.push_back(mk_result(KIND_ELEM_END, 8'd0, p_bs_run, cur_index()));
				p_open = 1'b0;
			end else begin
				r.push_back(mk_result(KIND_CHAR, c, p_bs_run, cur_index()));
			end
			p_bs_run = '0;
		end
		if (r.size() > 0)
			r[r.size()-1].last_of_run = 1'b1;
		foreach (r[i])
			pending_results.push_back(r[i]);
	endtask

	task automatic report(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("%s", msg);
	endtask

	// take input words into the prediction, check output words against it
	always @(posedge clk) begin
		qas_result_t got;
		qas_result_t want;
		word_in_taken = 1'b0;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				split_byte(s_tdata);
				bytes_taken++;
				word_in_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				got.kind               = qas_kind_t'(m_tuser);
				got.out_char           = m_tdata[7:0];
				got.backslashes_before = m_tdata[12:8];
				got.element_index      = m_tdata[20:13];
				got.last_of_run        = m_tlast;
				if (pending_results.size() == 0) begin
					report($sformatf("unexpected word %0d: kind %0d char %02h bs %0d idx %0d last %0b",
						results_seen, got.kind, got.out_char, got.backslashes_before,
						got.element_index, got.last_of_run));
				end else begin
					want = pending_results.pop_front();
					if (got.kind !== want.kind || got.out_char !== want.out_char ||
						got.backslashes_before !== want.backslashes_before ||
						got.element_index !== want.element_index ||
						got.last_of_run !== want.last_of_run) begin
						report($sformatf({"mismatch at word %0d: expected kind %0d char %02h ",
							"bs %0d idx %0d last %0b, got kind %0d char %02h bs %0d idx %0d last %0b"},
							results_seen, want.kind, want.out_char, want.backslashes_before,
							want.element_index, want.last_of_run, got.kind, got.out_char,
							got.backslashes_before, got.element_index, got.last_of_run));
					end
				end
				if (got.kind == KIND_STR_END)
					strings_ended++;
				if (got.kind != KIND_STR_END && int'(got.element_index) > max_index)
					max_index = got.element_index;
				results_seen++;
			end
		end
	end

	// sender: bursts of random length separated by random gaps
	int tx_burst = 0;
	int tx_gap   = 0;

	always @(negedge clk) begin
		logic       v;
		logic [7:0] d;
		v = s_tvalid;
		d = s_tdata;
		if (arst_n && (!s_tvalid || word_in_taken)) begin
			v = 1'b0;
			if (tx_gap > 0) begin
				tx_gap--;
			end else if (byte_q.size() > 0) begin
				if (byte_q[0].drain) begin
					// hold until every predicted word has come out
					if (pending_results.size() == 0) begin
						void'(byte_q.pop_front());
						drains_done++;
					end
				end else begin
					d = byte_q[0].ch;
					void'(byte_q.pop_front());
					v = 1'b1;
					if (tx_burst > 0) begin
						tx_burst--;
					end else begin
						tx_burst = $urandom_range(1, 40);
						tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
		s_tvalid <= v;
		s_tdata  <= d;
	end

	// receiver: stall rate changes per stretch, plus one long hold-off
	int rx_hold      = 0;
	int rx_span      = 0;
	int rx_stall_pct = 0;
	bit long_hold_done = 1'b0;

	always @(negedge clk) begin
		logic r;
		r = 1'b0;
		if (arst_n) begin
			if (rx_hold > 0) begin
				rx_hold--;
			end else if (!long_hold_done && bytes_taken >= HOLD_AT_BYTE) begin
				long_hold_done = 1'b1;
				rx_hold = LONG_HOLD;
			end else begin
				if (rx_span == 0) begin
					rx_span = $urandom_range(16, 200);
					case ($urandom_range(0, 3))
						0: rx_stall_pct = 0;
						1: rx_stall_pct = 20;
						2: rx_stall_pct = 50;
						default: rx_stall_pct = 85;
					endcase
				end
				rx_span--;
				r = ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
		m_tready <= r;
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected",
				cycle_count, pending_results.size());
			$display("quoted_argument_splitter_core_tb NOT OK");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		tx_entry_t e;
		e.drain = 1'b0;
		e.ch    = b;
		byte_q.push_back(e);
		if (!blank_byte(b))
			random_bytes++;
	endtask

	task automatic push_drain();
		tx_entry_t e;
		e.drain = 1'b1;
		e.ch    = '0;
		byte_q.push_back(e);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	task automatic push_blank();
		if ($urandom_range(0, 5) == 5)
			push_byte(CH_SPACE);
		else
			push_byte(CH_TAB + 8'($urandom_range(0, 4)));
	endtask

	// a string of random tokens: characters, backslash runs, quotes, blanks
	task automatic push_random_string();
		int n_tok;
		n_tok = $urandom_range(1, 24);
		for (int t = 0; t < n_tok; t++) begin
			case ($urandom_range(0, 9))
				0, 1, 2: push_byte(8'($urandom_range(8'h21, 8'h7E)));
				3:       repeat ($urandom_range(1, 4)) push_byte(CH_BSLASH);
				4, 5:    push_byte(CH_DQUOTE);
				6, 7:    push_blank();
				8:       push_byte(8'($urandom_range(1, 255)));
				default: begin
					if ($urandom_range(0, 15) == 0)
						repeat ($urandom_range(28, 40)) push_byte(CH_BSLASH);
					else
						push_byte(8'($urandom_range(8'h80, 8'hFF)));
				end
			endcase
		end
		push_byte(CH_NUL);
	endtask

	initial begin
		// directed: empty strings, plain chars, quoting rules, blank bytes
		push_byte(CH_NUL);
		push_byte(CH_NUL);
		push_byte(8'h61);
		push_byte(8'hFF);
		push_byte(CH_SPACE);
		push_byte(CH_TAB);
		push_text("\\\\\"x\"\"\" ");
		push_text("\\\"\\b\\");
		push_byte(CH_NUL);
		push_text("\"\"");
		push_byte(CH_NUL);
		push_byte(CH_CR);
		push_byte(8'h0B);
		push_byte(8'h7F);
		push_byte(8'h80);
		push_byte(CH_NUL);
		push_drain();

		// saturation: long backslash runs, then more elements than the counter holds
		repeat (40) push_byte(CH_BSLASH);
		push_byte(CH_DQUOTE);
		repeat (34) push_byte(CH_BSLASH);
		push_byte(8'h71);
		push_byte(CH_SPACE);
		repeat (260) begin
			push_byte(8'h65);
			push_blank();
		end
		push_text("\"q r\"");
		push_byte(CH_NUL);
		push_drain();

		// random: mostly well-formed strings, some raw noise
		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			if ($urandom_range(0, 6) == 0)
				repeat ($urandom_range(1, 30)) push_byte(8'($urandom_range(0, 255)));
			else
				push_random_string();
			if (!mid_drain_queued && random_bytes >= RANDOM_BYTES / 2 && byte_q.size() > 0 &&
				!byte_q[byte_q.size()-1].drain) begin
				push_drain();
				mid_drain_queued = 1'b1;
			end
		end
		push_byte(CH_NUL);

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// wait for the sender to empty its queue, then for the results
		while (byte_q.size() != 0 || s_tvalid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (pending_results.size() != 0)
			report($sformatf("%0d words never came out", pending_results.size()));
		$display("bytes in %0d, words out %0d, strings ended %0d, highest element index %0d",
			bytes_taken, results_seen, strings_ended, max_index);
		$display("directed quoting cases, saturated runs and counts, %0d queue drains, errors %0d",
			drains_done, errors);
		if (errors == 0)
			$display("quoted_argument_splitter_core_tb OK");
		else
			$display("quoted_argument_splitter_core_tb NOT OK");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/qas_pkg.sv
hw/rtl/qas_parser.sv
hw/rtl/qas_outq.sv
hw/rtl/quoted_argument_splitter_core.sv
tb/quoted_argument_splitter_core_tb.sv
